// ===== sv/dgrb_pkg.sv =====
// Package for the decimating gain ring buffer.
// Holds the field widths, reset values, mode codes and the per-item status record.
// Used by decimating_gain_ring_buffer; depends on nothing.
package dgrb_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned GAIN_W     = 15;
  localparam int unsigned FILL_W     = 10;
  localparam int unsigned DROP_W     = 32;
  localparam int unsigned GAIN_SHIFT = 8;

  localparam int unsigned DECIM_DEF = 4;
  localparam int unsigned DEPTH_DEF = 1024;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd256;

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sd32768;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_PUSH = 2'd1,
    KIND_POP  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [FILL_W-1:0]  fill;
    logic               ovf;
    logic [DROP_W-1:0]  drop;
  } ctl_t;

endpackage

// ===== sv/decimating_gain_ring_buffer.sv =====
// Decimating gain ring buffer: boxcar average, Q8 gain, overwrite-oldest ring.
// Single module; uses dgrb_pkg for widths, codes and the status record.
// Ring entries live in one synchronous memory accessed at the last pipeline stage.
//
// One item is accepted per clock cycle whenever the output side keeps up; every
// item yields exactly one result, from the last stage. The five register
// stages are: index and status update, magnitude times the reciprocal of DECIM,
// quotient correction, gain multiply, and the saturate plus ring memory access.
// The ring memory is read once per item and written for a push that closes a
// group, in item order, so a pop always sees every earlier push. Stalled
// stages hold; empty stages still fill while a finished result waits. The
// ring holds at most DEPTH-1 entries; its memory needs no clearing after reset,
// since a pop only ever returns written entries.
module decimating_gain_ring_buffer #(
  parameter int unsigned DECIM = dgrb_pkg::DECIM_DEF,
  parameter int unsigned DEPTH = dgrb_pkg::DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,

  input  logic                                  cfg_we_i,
  input  logic [dgrb_pkg::GAIN_W-1:0]           cfg_wdata_i,

  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            mode_i,
  input  logic signed [dgrb_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                  capture_on_i,

  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  result_valid_o,
  output logic signed [dgrb_pkg::SAMPLE_W-1:0]  out_sample_o,
  output logic [dgrb_pkg::FILL_W-1:0]           fill_level_o,
  output logic                                  overflow_seen_o,
  output logic [dgrb_pkg::DROP_W-1:0]           dropped_count_o
);

  localparam int unsigned SW      = dgrb_pkg::SAMPLE_W;
  localparam int unsigned SUM_W   = SW + $clog2(DECIM);
  localparam int unsigned CNT_W   = (DECIM > 1) ? $clog2(DECIM) : 1;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned P1_W    = SUM_W + SUM_W + 1;
  localparam int unsigned P2_W    = SW + dgrb_pkg::GAIN_W + 1;
  localparam int unsigned FW      = dgrb_pkg::FILL_W;

  localparam logic [SUM_W:0]   RECIP    = (SUM_W+1)'((64'd1 << SUM_W) / DECIM);
  localparam logic [SUM_W-1:0] DECIM_M  = SUM_W'(DECIM);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DECIM - 1);
  localparam logic [AW-1:0]    LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW:0]      DEPTH_F  = (AW+1)'(DEPTH);
  localparam logic signed [P2_W-1:0] HI_LIM = P2_W'(dgrb_pkg::SAT_MAX);
  localparam logic signed [P2_W-1:0] LO_LIM = P2_W'(dgrb_pkg::SAT_MIN);

  // architectural state
  logic [dgrb_pkg::GAIN_W-1:0] gain_q;
  logic signed [SUM_W-1:0]     sum_q, sum_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [AW-1:0]               rd_q, rd_d, wr_q, wr_d;
  logic                        ovf_q, ovf_d;
  logic [dgrb_pkg::DROP_W-1:0] drop_q, drop_d;

  // pipeline
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;
  logic acc;

  dgrb_pkg::ctl_t          ctl1_d, ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q;
  logic [AW-1:0]           addr1_d, addr1_q, addr2_q, addr3_q, addr4_q;
  logic signed [SUM_W-1:0] sum1_d, sum1_q;
  logic                    neg2_q;
  logic [SUM_W-1:0]        mag2_q;
  logic [P1_W-1:0]         prod2_q;
  logic signed [SW-1:0]    avg3_q;
  logic signed [P2_W-1:0]  prod4_q;
  logic signed [SW-1:0]    val5_q;
  logic signed [SW-1:0]    rdata5_q;

  logic signed [SW-1:0] ring_mem [DEPTH];

  // stage one helpers
  logic signed [SUM_W-1:0] samp_ext, sum_tot;
  logic [AW-1:0]           wr_inc, rd_inc;
  logic                    full;
  logic [AW:0]             fill_full;
  logic [FW+AW:0]          fill_ext;

  // later stage helpers
  logic                    neg1;
  logic [SUM_W-1:0]        mag1;
  logic [SUM_W-1:0]        q_est, rem2, q_fix;
  logic [SW:0]             q17;
  logic signed [SW-1:0]    avg2;
  logic signed [P2_W-1:0]  prod3;
  logic signed [P2_W-1:0]  shifted4;
  logic signed [SW-1:0]    sat4;

  assign en5 = !v5_q || out_ready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;
  assign acc = in_valid_i && en1;

  always_comb begin
    samp_ext = SUM_W'(sample_i);
    sum_tot  = sum_q + samp_ext;
    wr_inc   = (wr_q == LAST_IDX) ? '0 : wr_q + AW'(1);
    rd_inc   = (rd_q == LAST_IDX) ? '0 : rd_q + AW'(1);
    full     = (wr_inc == rd_q);

    sum_d   = sum_q;
    cnt_d   = cnt_q;
    rd_d    = rd_q;
    wr_d    = wr_q;
    ovf_d   = ovf_q;
    drop_d  = drop_q;
    addr1_d = wr_q;
    sum1_d  = sum_tot;
    ctl1_d.kind = dgrb_pkg::KIND_NONE;

    case (mode_i)
      dgrb_pkg::MODE_PUSH: begin
        if (capture_on_i) begin
          if (cnt_q == LAST_CNT) begin
            sum_d = '0;
            cnt_d = '0;
            ctl1_d.kind = dgrb_pkg::KIND_PUSH;
            wr_d = wr_inc;
            if (full) begin
              ovf_d  = 1'b1;
              drop_d = drop_q + 32'd1;
              rd_d   = rd_inc;
            end
          end else begin
            sum_d = sum_tot;
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      dgrb_pkg::MODE_POP: begin
        if (rd_q != wr_q) begin
          ctl1_d.kind = dgrb_pkg::KIND_POP;
          addr1_d = rd_q;
          rd_d = rd_inc;
        end
      end
      dgrb_pkg::MODE_CLEAR: begin
        sum_d  = '0;
        cnt_d  = '0;
        rd_d   = '0;
        wr_d   = '0;
        ovf_d  = 1'b0;
        drop_d = '0;
      end
      default: begin
      end
    endcase

    fill_full = {1'b0, wr_d} - {1'b0, rd_d};
    if (fill_full[AW]) begin
      fill_full = fill_full + DEPTH_F;
    end
    fill_ext    = (FW+AW+1)'(fill_full);
    ctl1_d.fill = fill_ext[FW-1:0];
    ctl1_d.ovf  = ovf_d;
    ctl1_d.drop = drop_d;
  end

  always_comb begin
    neg1 = sum1_q[SUM_W-1];
    mag1 = neg1 ? SUM_W'(-sum1_q) : SUM_W'(sum1_q);

    q_est = prod2_q[2*SUM_W-1:SUM_W];
    rem2  = mag2_q - SUM_W'(q_est * DECIM_M);
    q_fix = (rem2 >= DECIM_M) ? q_est + SUM_W'(1) : q_est;
    q17   = (SW+1)'(q_fix);
    avg2  = neg2_q ? SW'(-q17) : SW'(q17);

    prod3 = P2_W'(avg3_q) * P2_W'($signed({1'b0, gain_q}));

    shifted4 = prod4_q >>> dgrb_pkg::GAIN_SHIFT;
    if (shifted4 > HI_LIM) begin
      sat4 = dgrb_pkg::SAT_MAX;
    end else if (shifted4 < LO_LIM) begin
      sat4 = dgrb_pkg::SAT_MIN;
    end else begin
      sat4 = SW'(shifted4);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= dgrb_pkg::GAIN_RESET;
      sum_q  <= '0;
      cnt_q  <= '0;
      rd_q   <= '0;
      wr_q   <= '0;
      ovf_q  <= 1'b0;
      drop_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
      if (acc) begin
        sum_q  <= sum_d;
        cnt_q  <= cnt_d;
        rd_q   <= rd_d;
        wr_q   <= wr_d;
        ovf_q  <= ovf_d;
        drop_q <= drop_d;
      end
      if (en1) v1_q <= acc;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ctl1_q  <= ctl1_d;
      addr1_q <= addr1_d;
      sum1_q  <= sum1_d;
    end
    if (en2) begin
      ctl2_q  <= ctl1_q;
      addr2_q <= addr1_q;
      neg2_q  <= neg1;
      mag2_q  <= mag1;
      prod2_q <= P1_W'(mag1) * P1_W'(RECIP);
    end
    if (en3) begin
      ctl3_q  <= ctl2_q;
      addr3_q <= addr2_q;
      avg3_q  <= avg2;
    end
    if (en4) begin
      ctl4_q  <= ctl3_q;
      addr4_q <= addr3_q;
      prod4_q <= prod3;
    end
    if (en5) begin
      ctl5_q <= ctl4_q;
      val5_q <= sat4;
    end
  end

  // ring memory: one access per item, in item order
  always_ff @(posedge clk_i) begin
    if (en5 && v4_q) begin
      if (ctl4_q.kind == dgrb_pkg::KIND_PUSH) begin
        ring_mem[addr4_q] <= sat4;
      end
      rdata5_q <= ring_mem[addr4_q];
    end
  end

  assign out_valid_o     = v5_q;
  assign result_valid_o  = (ctl5_q.kind != dgrb_pkg::KIND_NONE);
  assign out_sample_o    = (ctl5_q.kind == dgrb_pkg::KIND_POP)  ? rdata5_q :
                           (ctl5_q.kind == dgrb_pkg::KIND_PUSH) ? val5_q : '0;
  assign fill_level_o    = ctl5_q.fill;
  assign overflow_seen_o = ctl5_q.ovf;
  assign dropped_count_o = ctl5_q.drop;

  a_empty_front_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> in_ready_o)
    else $error("front stage empty but input not ready");

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && mode_i == dgrb_pkg::MODE_CLEAR) |=>
      (rd_q == '0 && wr_q == '0 && drop_q == '0 && !ovf_q && cnt_q == '0))
    else $error("clear left state behind");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovf_q && !(acc && mode_i == dgrb_pkg::MODE_CLEAR)) |=> ovf_q)
    else $error("overflow flag dropped without clear");

  a_drop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> $stable(drop_q) && $stable(rd_q) && $stable(wr_q))
    else $error("ring state changed without an item");

  a_drop_with_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && mode_i != dgrb_pkg::MODE_CLEAR && drop_d != drop_q) |-> ovf_d)
    else $error("drop counted without overflow flag");

endmodule

// ===== tb/testbench.sv =====
// Testbench for decimating_gain_ring_buffer: directed and random items, with a shadow ring.
// Depends on dgrb_pkg and the block's RTL; each result is checked against the shadow model.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned RING_SLOTS = dgrb_pkg::DEPTH_DEF;
  localparam int unsigned GROUP_LEN  = dgrb_pkg::DECIM_DEF;

  typedef logic signed [dgrb_pkg::SAMPLE_W-1:0] smp_t;
  typedef logic [dgrb_pkg::GAIN_W-1:0]          gain_t;
  typedef logic [dgrb_pkg::FILL_W-1:0]          fill_t;
  typedef logic [dgrb_pkg::DROP_W-1:0]          drop_t;

  typedef struct {
    logic  rv;
    smp_t  smp;
    fill_t fill;
    logic  ovf;
    drop_t drop;
  } ring_status_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  gain_t       cfg_wdata_i  = '0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i       = dgrb_pkg::MODE_PUSH;
  smp_t        sample_i     = '0;
  logic        capture_on_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic        result_valid_o;
  smp_t        out_sample_o;
  fill_t       fill_level_o;
  logic        overflow_seen_o;
  drop_t       dropped_count_o;

  ring_status_t ring_status_q[$];

  int          acc_sum;
  int          acc_count;
  smp_t        shadow_ring [RING_SLOTS];
  int unsigned rd_ix;
  int unsigned wr_ix;
  logic        shadow_ovf;
  drop_t       shadow_drops;
  gain_t       shadow_gain;

  int  errors      = 0;
  int  n_items     = 0;
  int  n_checked   = 0;
  int  n_stored    = 0;
  int  n_popped    = 0;
  int  max_drops   = 0;
  int  gain_writes = 0;
  bit  no_gaps     = 1'b0;

  decimating_gain_ring_buffer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .sample_i        (sample_i),
    .capture_on_i    (capture_on_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_valid_o  (result_valid_o),
    .out_sample_o    (out_sample_o),
    .fill_level_o    (fill_level_o),
    .overflow_seen_o (overflow_seen_o),
    .dropped_count_o (dropped_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic smp_t scale_average(int avg);
    longint prod;
    longint q;
    prod = longint'(avg) * longint'(shadow_gain);
    q    = prod >>> dgrb_pkg::GAIN_SHIFT;
    if (q > 32767) return dgrb_pkg::SAT_MAX;
    if (q < -32768) return dgrb_pkg::SAT_MIN;
    return q[dgrb_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic int unsigned ring_fill();
    return (wr_ix + RING_SLOTS - rd_ix) % RING_SLOTS;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic smp_t pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return dgrb_pkg::SAT_MAX;
    if (r < 16) return dgrb_pkg::SAT_MIN;
    if (r < 24) return smp_t'(int'($urandom_range(0, 7)) - 4);
    return smp_t'($urandom_range(0, 65535));
  endfunction

  task automatic reset_shadow();
    acc_sum      = 0;
    acc_count    = 0;
    rd_ix        = 0;
    wr_ix        = 0;
    shadow_ovf   = 1'b0;
    shadow_drops = '0;
  endtask

  task automatic average_into_ring(dgrb_pkg::mode_e m, smp_t s, logic cap);
    ring_status_t st;
    int unsigned  nxt;
    st.rv  = 1'b0;
    st.smp = '0;
    case (m)
      dgrb_pkg::MODE_PUSH: begin
        if (cap) begin
          acc_sum += int'(s);
          acc_count++;
          if (acc_count >= GROUP_LEN) begin
            st.smp    = scale_average(acc_sum / int'(GROUP_LEN));
            acc_sum   = 0;
            acc_count = 0;
            nxt = (wr_ix + 1) % RING_SLOTS;
            if (nxt == rd_ix) begin
              shadow_ovf   = 1'b1;
              shadow_drops = shadow_drops + 1;
              rd_ix        = (rd_ix + 1) % RING_SLOTS;
            end
            shadow_ring[wr_ix] = st.smp;
            wr_ix = nxt;
            st.rv = 1'b1;
            n_stored++;
          end
        end
      end
      dgrb_pkg::MODE_POP: begin
        if (rd_ix != wr_ix) begin
          st.smp = shadow_ring[rd_ix];
          rd_ix  = (rd_ix + 1) % RING_SLOTS;
          st.rv  = 1'b1;
          n_popped++;
        end
      end
      dgrb_pkg::MODE_CLEAR: reset_shadow();
      default: ;
    endcase
    st.fill = fill_t'(ring_fill());
    st.ovf  = shadow_ovf;
    st.drop = shadow_drops;
    if (int'(shadow_drops) > max_drops) max_drops = int'(shadow_drops);
    ring_status_q.push_back(st);
  endtask

  task automatic send_item(dgrb_pkg::mode_e m, smp_t s, logic cap);
    int gap;
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    sample_i     <= s;
    capture_on_i <= cap;
    do @(posedge clk_i); while (!in_ready_o);
    average_into_ring(m, s, cap);
    n_items++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (ring_status_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_gain(gain_t g);
    drain_results();
    cfg_wdata_i <= g;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_gain = g;
    gain_writes++;
    @(posedge clk_i);
  endtask

  task automatic report_field(string name, longint want, longint got);
    errors++;
    $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
  endtask

  always @(posedge clk_i) begin : check_outputs
    ring_status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (ring_status_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual out_sample %0d",
                 $time, out_sample_o);
      end else begin
        want = ring_status_q.pop_front();
        n_checked++;
        if (result_valid_o !== want.rv)
          report_field("result_valid", want.rv, result_valid_o);
        if (out_sample_o !== want.smp)
          report_field("out_sample", want.smp, out_sample_o);
        if (fill_level_o !== want.fill)
          report_field("fill_level", want.fill, fill_level_o);
        if (overflow_seen_o !== want.ovf)
          report_field("overflow_seen", want.ovf, overflow_seen_o);
        if (dropped_count_o !== want.drop)
          report_field("dropped_count", want.drop, dropped_count_o);
      end
    end
  end

  initial begin : drive_out_ready
    int hold;
    int r;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_ready_i <= 1'b1;
          hold = $urandom_range(0, 7);
        end else if (r < 85) begin
          out_ready_i <= 1'b0;
          hold = $urandom_range(0, 2);
        end else if (r < 92) begin
          out_ready_i <= 1'b0;
          hold = $urandom_range(10, 40);
        end else begin
          out_ready_i <= 1'b1;
          hold = $urandom_range(60, 200);
        end
      end
    end
  end

  task automatic test_idle_status();
    send_item(dgrb_pkg::MODE_POP, dgrb_pkg::SAT_MIN, 1'b1);
    send_item(dgrb_pkg::MODE_NONE, dgrb_pkg::SAT_MAX, 1'b1);
    send_item(dgrb_pkg::MODE_PUSH, dgrb_pkg::SAT_MAX, 1'b0);
  endtask

  task automatic test_directed_groups();
    repeat (GROUP_LEN) send_item(dgrb_pkg::MODE_PUSH, dgrb_pkg::SAT_MAX, 1'b1);
    send_item(dgrb_pkg::MODE_PUSH, 16'sd1, 1'b1);
    send_item(dgrb_pkg::MODE_PUSH, 16'sd2, 1'b1);
    send_item(dgrb_pkg::MODE_PUSH, -16'sd3, 1'b1);
    send_item(dgrb_pkg::MODE_PUSH, -16'sd2, 1'b1);
    send_item(dgrb_pkg::MODE_POP, 16'sd0, 1'b0);
    send_item(dgrb_pkg::MODE_PUSH, -16'sd5, 1'b1);
    send_item(dgrb_pkg::MODE_CLEAR, 16'sd0, 1'b1);
    set_gain(15'd32767);
    repeat (GROUP_LEN) send_item(dgrb_pkg::MODE_PUSH, dgrb_pkg::SAT_MIN, 1'b1);
    set_gain(15'd1);
    repeat (GROUP_LEN) send_item(dgrb_pkg::MODE_PUSH, -16'sd1, 1'b1);
    repeat (3) send_item(dgrb_pkg::MODE_POP, 16'sd0, 1'b1);
  endtask

  task automatic test_ring_fill();
    set_gain(dgrb_pkg::GAIN_RESET);
    no_gaps = 1'b1;
    repeat (GROUP_LEN * 100) begin
      if ($urandom_range(0, 99) < 5) no_gaps = ~no_gaps;
      send_item(dgrb_pkg::MODE_PUSH, pick_sample(), 1'b1);
    end
    no_gaps = 1'b0;
    repeat (40) send_item(dgrb_pkg::MODE_POP, pick_sample(), 1'b0);
    repeat (GROUP_LEN * 2) send_item(dgrb_pkg::MODE_PUSH, pick_sample(), 1'b1);
    send_item(dgrb_pkg::MODE_NONE, pick_sample(), 1'b1);
    send_item(dgrb_pkg::MODE_CLEAR, pick_sample(), 1'b1);
  endtask

  task automatic test_random_traffic();
    gain_t gains [5];
    int    r;
    gains[0] = 15'd0;
    gains[1] = 15'd32767;
    gains[2] = dgrb_pkg::GAIN_RESET;
    gains[3] = gain_t'($urandom_range(1, 1023));
    gains[4] = gain_t'($urandom_range(0, 32767));
    for (int ph = 0; ph < 5; ph++) begin
      set_gain(gains[ph]);
      for (int k = 0; k < 175; k++) begin
        if (k % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        if (ph == 2 && k == 87) drain_results();
        r = $urandom_range(0, 99);
        if (r < 68) send_item(dgrb_pkg::MODE_PUSH, pick_sample(), 1'b1);
        else if (r < 76) send_item(dgrb_pkg::MODE_PUSH, pick_sample(), 1'b0);
        else if (r < 90)
          send_item(dgrb_pkg::MODE_POP, pick_sample(), 1'($urandom_range(0, 1)));
        else if (r < 93)
          send_item(dgrb_pkg::MODE_CLEAR, pick_sample(), 1'($urandom_range(0, 1)));
        else send_item(dgrb_pkg::MODE_NONE, pick_sample(), 1'($urandom_range(0, 1)));
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    reset_shadow();
    shadow_gain = dgrb_pkg::GAIN_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_idle_status();
    test_directed_groups();
    test_ring_fill();
    test_random_traffic();
    drain_results();
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d items and %0d results over %0d gain settings.",
             n_items, n_checked, gain_writes);
    $display("Stored %0d averaged samples, popped %0d, peak drop count %0d.",
             n_stored, n_popped, max_drops);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dgrb_pkg.sv
sv/decimating_gain_ring_buffer.sv
tb/testbench.sv
